@@ rtl/second_shortest_path_engine_assert.svh @@
// ----------------------------------------------------------------------------
// second_shortest_path_engine_assert
// assertion macros shared by the second shortest path engine rtl
// ----------------------------------------------------------------------------
`ifndef SECOND_SHORTEST_PATH_ENGINE_ASSERT_SVH
`define SECOND_SHORTEST_PATH_ENGINE_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define SSP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition in one cycle that implies another in the next cycle
`define SSP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/ssp_pkg.sv @@
// ----------------------------------------------------------------------------
// ssp_pkg
// op codes, register indexes and shared types of the second shortest path engine
// ----------------------------------------------------------------------------
package ssp_pkg;

    // input item op codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_RUN    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic CFG_SOURCE = 1'b0;
    localparam logic CFG_TARGET = 1'b1;

    localparam int CFG_BITS  = 12;
    localparam int NODE_BITS_IN = 12;

    // outcome of offering a candidate distance to a node
    typedef struct packed {
        logic take_best;
        logic take_next;
    } offer_flags_t;

endpackage

@@ rtl/ssp_relax_unit.sv @@
// ----------------------------------------------------------------------------
// ssp_relax_unit
// shared saturating adder and offer comparator for the relaxation sequencer
// ----------------------------------------------------------------------------
module ssp_relax_unit #(
    parameter int DIST_BITS   = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  logic [DIST_BITS-1:0]   base_dist,
    input  logic [WEIGHT_BITS-1:0] weight,
    input  logic [DIST_BITS-1:0]   cand,
    input  logic [DIST_BITS-1:0]   best,
    input  logic [DIST_BITS-1:0]   nxt,
    output logic [DIST_BITS-1:0]   sum,
    output ssp_pkg::offer_flags_t  flags
);
    import ssp_pkg::*;

    localparam int SW = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
    localparam logic [DIST_BITS-1:0] INF = {DIST_BITS{1'b1}};

    logic [SW-1:0] wide_sum;
    logic          cand_fin;

    // saturating add, infinity in gives infinity out
    assign wide_sum = SW'(base_dist) + SW'(weight);
    assign sum = ((base_dist == INF) || (wide_sum >= SW'(INF))) ? INF
                                                                : wide_sum[DIST_BITS-1:0];

    // offer compare against the node's best and next-best values
    assign cand_fin        = (cand != INF);
    assign flags.take_best = cand_fin && (cand < best);
    assign flags.take_next = cand_fin && (cand > best) && (cand < nxt);

endmodule

@@ rtl/second_shortest_path_engine.sv @@
// ----------------------------------------------------------------------------
// second_shortest_path_engine
// loads undirected roads and finds the second shortest walk length to a target
// ----------------------------------------------------------------------------
// Clear and add-road items are taken without leaving the idle state. A run first
// sweeps the node distance memory, then walks the edge store in passes until a
// pass changes nothing: each road is handled as one edge read, then 7 steps for
// each direction through the shared add/compare unit on the single read port of
// the node memory; each pass ends with a pass check, and the target is then read
// and reported. The block takes no item while a run is in progress.
module second_shortest_path_engine #(
    parameter int MAX_NODES   = 4096,
    parameter int MAX_EDGES   = 8192,
    parameter int WEIGHT_BITS = 16,
    parameter int DIST_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [11:0] end_a,
    input  logic [11:0] end_b,
    input  logic [15:0] road_weight,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] second_distance,
    output logic        found,
    output logic        overflow
);
    import ssp_pkg::*;

    localparam int NB  = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int EB  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CB  = $clog2(MAX_EDGES + 1);
    localparam int EW  = 2 * NB + WEIGHT_BITS;
    localparam int PW  = 2 * DIST_BITS;
    localparam logic [DIST_BITS-1:0] INF = {DIST_BITS{1'b1}};

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_FILL = 13'b0000000000010,
        S_ERD  = 13'b0000000000100,
        S_RDU  = 13'b0000000001000,
        S_RDV  = 13'b0000000010000,
        S_ADD1 = 13'b0000000100000,
        S_CMP1 = 13'b0000001000000,
        S_ADD2 = 13'b0000010000000,
        S_CMP2 = 13'b0000100000000,
        S_WR   = 13'b0001000000000,
        S_PASS = 13'b0010000000000,
        S_TRD  = 13'b0100000000000,
        S_TLAT = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [11:0]            source_reg, target_reg;
    logic [CB-1:0]          edge_count_reg;
    logic                   overflow_reg;
    logic                   changed_reg;
    logic [EB-1:0]          edge_idx_reg;
    logic [NB-1:0]          fill_idx_reg;
    logic                   dir_reg;
    logic [DIST_BITS-1:0]   ub_reg, un_reg, vb_reg, vn_reg, cand_reg;
    logic                   out_valid_reg;
    logic [31:0]            out_dist_reg;
    logic                   out_found_reg;
    logic                   out_ovf_reg;

    logic [EW-1:0]          edge_mem [MAX_EDGES];
    logic [EW-1:0]          edge_q;
    logic [PW-1:0]          node_mem [MAX_NODES];
    logic [PW-1:0]          node_q;

    logic                   accept;
    logic [31:0]            a32, b32, src32, tgt32;
    logic                   a_ok, b_ok, src_ok, tgt_ok;
    logic [NB-1:0]          a_idx, b_idx, src_idx, tgt_idx;
    logic [31:0]            w32;
    logic [WEIGHT_BITS-1:0] w_in;
    logic                   edge_full;
    logic                   edge_last;
    logic [NB-1:0]          e_a, e_b, u_idx, v_idx;
    logic [WEIGHT_BITS-1:0] e_w;
    logic [NB-1:0]          rd_addr;
    logic                   node_we;
    logic [NB-1:0]          wr_addr;
    logic [PW-1:0]          wr_data;
    logic [DIST_BITS-1:0]   alu_dist, alu_sum;
    offer_flags_t           alu_flags;
    logic [DIST_BITS-1:0]   tgt_d;
    logic [63:0]            tgt_d64;
    logic                   tgt_fin;
    logic                   out_load;

    // input decode and range checks
    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign a32   = 32'(end_a);
    assign b32   = 32'(end_b);
    assign src32 = 32'(source_reg);
    assign tgt32 = 32'(target_reg);
    assign a_ok   = a32 < 32'(MAX_NODES);
    assign b_ok   = b32 < 32'(MAX_NODES);
    assign src_ok = src32 < 32'(MAX_NODES);
    assign tgt_ok = tgt32 < 32'(MAX_NODES);
    assign a_idx   = a32[NB-1:0];
    assign b_idx   = b32[NB-1:0];
    assign src_idx = src32[NB-1:0];
    assign tgt_idx = tgt32[NB-1:0];
    assign w32   = 32'(road_weight);
    assign w_in  = w32[WEIGHT_BITS-1:0];
    assign edge_full = (edge_count_reg == CB'(MAX_EDGES));
    assign edge_last = (CB'(edge_idx_reg) == edge_count_reg - CB'(1));

    // fields of the road being relaxed, near end u and far end v
    assign e_w = edge_q[WEIGHT_BITS-1:0];
    assign e_b = edge_q[WEIGHT_BITS +: NB];
    assign e_a = edge_q[WEIGHT_BITS+NB +: NB];
    assign u_idx = dir_reg ? e_b : e_a;
    assign v_idx = dir_reg ? e_a : e_b;

    // edge store
    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_ADD) && a_ok && b_ok && !edge_full)
        begin
            edge_mem[edge_count_reg[EB-1:0]] <= {a_idx, b_idx, w_in};
        end
        if (state_reg == S_ERD)
        begin
            edge_q <= edge_mem[edge_idx_reg];
        end
    end

    // node distance memory port selection, target held while the result waits
    always_comb
    begin
        case (state_reg)
            S_RDV:         rd_addr = v_idx;
            S_TRD, S_TLAT: rd_addr = tgt_idx;
            default:       rd_addr = u_idx;
        endcase
        node_we = (state_reg == S_FILL) || (state_reg == S_WR);
        wr_addr = (state_reg == S_FILL) ? fill_idx_reg : v_idx;
        if (state_reg == S_FILL)
        begin
            wr_data = {((src_ok && (fill_idx_reg == src_idx)) ? '0 : INF), INF};
        end
        else
        begin
            wr_data = {vb_reg, vn_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[wr_addr] <= wr_data;
        end
        node_q <= node_mem[rd_addr];
    end

    // shared add and offer unit
    assign alu_dist = (state_reg == S_ADD2) ? ((u_idx == v_idx) ? vn_reg : un_reg) : ub_reg;

    ssp_relax_unit #(
        .DIST_BITS   (DIST_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_relax (
        .base_dist (alu_dist),
        .weight    (e_w),
        .cand      (cand_reg),
        .best      (vb_reg),
        .nxt       (vn_reg),
        .sum       (alu_sum),
        .flags     (alu_flags)
    );

    // report value from the target's next-best slot
    assign tgt_d   = tgt_ok ? node_q[DIST_BITS-1:0] : INF;
    assign tgt_fin = (tgt_d != INF);
    assign tgt_d64 = 64'(tgt_d);
    assign out_load = (state_reg == S_TLAT) && (!out_valid_reg || out_ready);

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (op == OP_RUN))
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (fill_idx_reg == NB'(MAX_NODES - 1))
                begin
                    state_next = (src_ok && (edge_count_reg != '0)) ? S_ERD : S_TRD;
                end
            end
            S_ERD:  state_next = S_RDU;
            S_RDU:  state_next = S_RDV;
            S_RDV:  state_next = S_ADD1;
            S_ADD1: state_next = S_CMP1;
            S_CMP1: state_next = S_ADD2;
            S_ADD2: state_next = S_CMP2;
            S_CMP2: state_next = S_WR;
            S_WR:
            begin
                if (!dir_reg)
                begin
                    state_next = S_RDU;
                end
                else
                begin
                    state_next = edge_last ? S_PASS : S_ERD;
                end
            end
            S_PASS: state_next = changed_reg ? S_ERD : S_TRD;
            S_TRD:  state_next = S_TLAT;
            S_TLAT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            source_reg     <= 12'd1;
            target_reg     <= 12'd1;
            edge_count_reg <= '0;
            overflow_reg   <= 1'b0;
            changed_reg    <= 1'b0;
            edge_idx_reg   <= '0;
            fill_idx_reg   <= '0;
            dir_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SOURCE: source_reg <= cfg_data;
                    CFG_TARGET: target_reg <= cfg_data;
                    default:    source_reg <= source_reg;
                endcase
            end

            // graph loading and clearing
            if (accept)
            begin
                case (op)
                    OP_CLEAR:
                    begin
                        edge_count_reg <= '0;
                        overflow_reg   <= 1'b0;
                    end
                    OP_ADD:
                    begin
                        if (a_ok && b_ok)
                        begin
                            if (edge_full)
                            begin
                                overflow_reg <= 1'b1;
                            end
                            else
                            begin
                                edge_count_reg <= edge_count_reg + CB'(1);
                            end
                        end
                    end
                    OP_RUN:
                    begin
                        fill_idx_reg <= '0;
                    end
                    default:
                    begin
                        fill_idx_reg <= fill_idx_reg;
                    end
                endcase
            end

            // clearing sweep and pass bookkeeping
            if (state_reg == S_FILL)
            begin
                fill_idx_reg <= fill_idx_reg + NB'(1);
                edge_idx_reg <= '0;
                changed_reg  <= 1'b0;
                dir_reg      <= 1'b0;
            end
            if ((state_reg == S_CMP1) || (state_reg == S_CMP2))
            begin
                if (alu_flags.take_best || alu_flags.take_next)
                begin
                    changed_reg <= 1'b1;
                end
            end
            if (state_reg == S_WR)
            begin
                dir_reg <= !dir_reg;
                if (dir_reg && !edge_last)
                begin
                    edge_idx_reg <= edge_idx_reg + EB'(1);
                end
            end
            if (state_reg == S_PASS)
            begin
                edge_idx_reg <= '0;
                changed_reg  <= 1'b0;
            end

            // result handshake
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_RDV:
            begin
                ub_reg <= node_q[PW-1:DIST_BITS];
                un_reg <= node_q[DIST_BITS-1:0];
            end
            S_ADD1:
            begin
                vb_reg   <= node_q[PW-1:DIST_BITS];
                vn_reg   <= node_q[DIST_BITS-1:0];
                cand_reg <= alu_sum;
            end
            S_ADD2:
            begin
                cand_reg <= alu_sum;
            end
            S_CMP1, S_CMP2:
            begin
                if (alu_flags.take_best)
                begin
                    vn_reg <= vb_reg;
                    vb_reg <= cand_reg;
                end
                else if (alu_flags.take_next)
                begin
                    vn_reg <= cand_reg;
                end
            end
            default:
            begin
                cand_reg <= cand_reg;
            end
        endcase
        if (out_load)
        begin
            out_found_reg <= tgt_fin;
            out_ovf_reg   <= overflow_reg;
            out_dist_reg  <= (!tgt_fin || (tgt_d64 > 64'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                    : tgt_d64[31:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign second_distance = out_dist_reg;
    assign found           = out_found_reg;
    assign overflow        = out_ovf_reg;

`include "second_shortest_path_engine_assert.svh"

    // checks on the sequencer and node values
    `SSP_ASSERT_ALWAYS(a_count_range, edge_count_reg <= CB'(MAX_EDGES), "edge count beyond capacity")
    `SSP_ASSERT_NEXT(a_ovf_set, accept && (op == OP_ADD) && a_ok && b_ok && edge_full, overflow_reg, "dropped road did not set overflow")
    `SSP_ASSERT_ALWAYS(a_order, (state_reg != S_WR) || (vb_reg < vn_reg) || (vb_reg == INF), "best not below next-best at write back")

endmodule
